### hw/rtl/http_request_header_tokenizer_unit_defines.svh
// ----------------------------------------------------------------------------
// HTTP request header tokenizer assertion macros
// Shared property wrappers, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef HTTP_REQUEST_HEADER_TOKENIZER_UNIT_DEFINES_SVH
`define HTTP_REQUEST_HEADER_TOKENIZER_UNIT_DEFINES_SVH

// same-cycle implication
`define HRHT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hrht: implication failed");

// next-cycle implication
`define HRHT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hrht: next-cycle implication failed");

`endif

### hw/rtl/hrht_pkg.sv
// ----------------------------------------------------------------------------
// hrht_pkg
// Types, constants and helper functions of the HTTP request header tokenizer.
// ----------------------------------------------------------------------------
package hrht_pkg;

    localparam int MAX_HEADERS  = 16;
    localparam int BUFFER_BYTES = 65536;
    localparam int LC_W         = $clog2(MAX_HEADERS + 1);
    localparam int POS_W        = 16;
    localparam int HN_MAX       = 15;

    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_HT    = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;

    typedef enum logic [3:0] {
        PH_METHOD   = 4'd0,
        PH_URI      = 4'd1,
        PH_VERSION  = 4'd2,
        PH_LINE     = 4'd3,
        PH_NAME     = 4'd4,
        PH_VALUE    = 4'd5,
        PH_LINE_CR  = 4'd6,
        PH_VAL_LF   = 4'd7,
        PH_VAL_CR   = 4'd8,
        PH_VAL_CRLF = 4'd9,
        PH_DONE     = 4'd10
    } t_phase;

    typedef enum logic [2:0] {
        ROLE_METHOD  = 3'd0,
        ROLE_URI     = 3'd1,
        ROLE_VERSION = 3'd2,
        ROLE_NAME    = 3'd3,
        ROLE_VALUE   = 3'd4,
        ROLE_DROP    = 3'd5,
        ROLE_AFTER   = 3'd6
    } t_role;

    typedef enum logic [1:0] {
        ST_RUN      = 2'd0,
        ST_COMPLETE = 2'd1,
        ST_END      = 2'd2,
        ST_MANY     = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0]       out_byte;
        t_role            role;
        logic [3:0]       header_number;
        logic [POS_W-1:0] byte_position;
        t_status          parse_status;
    } t_result;

    function automatic logic f_blank(input logic [7:0] b);
        return (b == CH_SP) || (b == CH_HT);
    endfunction

    function automatic t_status f_fin(input t_status fs, input t_status st);
        return (fs == ST_RUN) ? st : fs;
    endfunction

    function automatic logic [POS_W-1:0] f_pos_inc(input logic [POS_W-1:0] p);
        return (p == POS_W'(BUFFER_BYTES - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [POS_W-1:0] f_pos_sub(input logic [POS_W-1:0] p,
                                                   input logic [1:0] k);
        logic [POS_W:0] s;
        if (p >= POS_W'(k)) begin
            s = {1'b0, p} - (POS_W+1)'(k);
        end else begin
            s = {1'b0, p} + (POS_W+1)'(BUFFER_BYTES) - (POS_W+1)'(k);
        end
        return s[POS_W-1:0];
    endfunction

    function automatic t_result f_res(input logic [7:0] b, input t_role role,
                                      input logic [LC_W-1:0] lc,
                                      input logic [POS_W-1:0] pos,
                                      input t_status fs);
        t_result r;
        r.out_byte      = b;
        r.role          = role;
        r.header_number = (int'(lc) > HN_MAX) ? 4'(HN_MAX) : 4'(lc);
        r.byte_position = pos;
        r.parse_status  = fs;
        return r;
    endfunction

endpackage

### hw/rtl/hrht_in_if.sv
// ----------------------------------------------------------------------------
// hrht_in_if
// Request byte channel: valid/ready handshake with one byte and its flags.
// ----------------------------------------------------------------------------
interface hrht_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_data;
    logic       first_of_message;

    modport source (output valid, output in_byte, output end_of_data,
                     output first_of_message, input ready);
    modport sink (input valid, input in_byte, input end_of_data,
                  input first_of_message, output ready);
endinterface

### hw/rtl/hrht_out_if.sv
// ----------------------------------------------------------------------------
// hrht_out_if
// Tagged byte channel: valid/ready handshake with one classified byte.
// ----------------------------------------------------------------------------
interface hrht_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic [2:0]  role;
    logic [3:0]  header_number;
    logic [15:0] byte_position;
    logic [1:0]  parse_status;
    logic        last_of_run;

    modport source (output valid, output out_byte, output role, output header_number,
                     output byte_position, output parse_status, output last_of_run,
                     input ready);
    modport sink (input valid, input out_byte, input role, input header_number,
                  input byte_position, input parse_status, input last_of_run,
                  output ready);
endinterface

### hw/rtl/http_request_header_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// http_request_header_tokenizer_unit
// Results of an accepted byte are registered and offered on o_out the next cycle.
// Throughput: one byte per cycle while each byte yields at most one result and o_out
//   is ready; a byte yielding k results (k up to 3) holds the input until the single
//   result port has drained all k of them from the result buffer.
// Reset: synchronous, active low; clears all parse state, ready rises in the
//   cycle after reset is released.
// ----------------------------------------------------------------------------
`include "http_request_header_tokenizer_unit_defines.svh"

module http_request_header_tokenizer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hrht_in_if.sink     i_in,
    hrht_out_if.source  o_out
);

    typedef enum logic [2:0] {
        MD_NONE,
        MD_REQ,
        MD_LINE,
        MD_NAME,
        MD_VALUE
    } t_mode;

    // parse state
    hrht_pkg::t_phase                 r_ph, n_ph;
    logic [hrht_pkg::LC_W-1:0]        r_lc, n_lc;
    logic                             r_vs, n_vs;
    logic                             r_nbs, n_nbs;
    hrht_pkg::t_status                r_fs, n_fs;
    logic [1:0]                       r_pc, n_pc;
    logic [7:0]                       r_p0, n_p0;
    logic [7:0]                       r_p1, n_p1;
    logic [hrht_pkg::POS_W-1:0]       r_posc, n_posc;

    // result buffer
    hrht_pkg::t_result                r_res [3];
    logic [1:0]                       r_cnt;
    logic [1:0]                       r_idx;
    logic                             r_run;

    hrht_pkg::t_result                c_res [3];
    logic [1:0]                       c_n;
    t_mode                            c_mode;
    hrht_pkg::t_role                  c_role;
    logic [hrht_pkg::POS_W-1:0]       c_pos;
    logic [hrht_pkg::POS_W-1:0]       c_q0;
    logic [hrht_pkg::POS_W-1:0]       c_q1;
    logic [7:0]                       c_b;
    logic                             c_last;

    logic in_acc;
    logic out_acc;
    logic out_last;

    assign out_last    = (r_idx == (r_cnt - 2'd1));
    assign o_out.valid = (r_cnt != 2'd0);
    assign out_acc     = o_out.valid && o_out.ready;
    assign i_in.ready  = r_run && ((r_cnt == 2'd0) || (o_out.ready && out_last));
    assign in_acc      = i_in.valid && i_in.ready;

    assign o_out.out_byte      = r_res[r_idx].out_byte;
    assign o_out.role          = r_res[r_idx].role;
    assign o_out.header_number = r_res[r_idx].header_number;
    assign o_out.byte_position = r_res[r_idx].byte_position;
    assign o_out.parse_status  = r_res[r_idx].parse_status;
    assign o_out.last_of_run   = out_last;

    always_comb begin
        c_b    = i_in.in_byte;
        c_last = i_in.end_of_data;
        n_ph   = r_ph;
        n_lc   = r_lc;
        n_vs   = r_vs;
        n_nbs  = r_nbs;
        n_fs   = r_fs;
        n_pc   = r_pc;
        n_p0   = r_p0;
        n_p1   = r_p1;
        c_n    = 2'd0;
        c_mode = MD_NONE;
        c_role = hrht_pkg::ROLE_DROP;
        c_res[0] = '0;
        c_res[1] = '0;
        c_res[2] = '0;
        c_q0   = hrht_pkg::f_pos_sub(r_posc, r_pc);
        c_q1   = hrht_pkg::f_pos_inc(c_q0);
        c_pos  = r_posc;

        // restart: flush waiting bytes for the old request
        if (i_in.first_of_message) begin
            if (r_pc != 2'd0 && r_ph != hrht_pkg::PH_DONE) begin
                n_fs = hrht_pkg::f_fin(n_fs, hrht_pkg::ST_END);
                c_res[c_n] = hrht_pkg::f_res(r_p0, hrht_pkg::ROLE_DROP, n_lc, c_q0, n_fs);
                c_n = c_n + 2'd1;
                if (r_pc == 2'd2) begin
                    c_res[c_n] = hrht_pkg::f_res(r_p1, hrht_pkg::ROLE_DROP, n_lc, c_q1,
                                                 n_fs);
                    c_n = c_n + 2'd1;
                end
            end
            n_ph  = hrht_pkg::PH_METHOD;
            n_p0  = '0;
            n_p1  = '0;
            n_pc  = '0;
            n_lc  = '0;
            n_vs  = 1'b0;
            n_nbs = 1'b0;
            n_fs  = hrht_pkg::ST_RUN;
            c_pos = '0;
        end
        n_posc = hrht_pkg::f_pos_inc(c_pos);

        // lookahead resolution and dispatch
        unique case (n_ph)
            hrht_pkg::PH_METHOD, hrht_pkg::PH_URI, hrht_pkg::PH_VERSION: begin
                c_mode = MD_REQ;
            end
            hrht_pkg::PH_LINE: begin
                c_mode = MD_LINE;
            end
            hrht_pkg::PH_NAME: begin
                c_mode = MD_NAME;
            end
            hrht_pkg::PH_VALUE: begin
                c_mode = MD_VALUE;
            end
            hrht_pkg::PH_LINE_CR: begin
                n_pc = 2'd0;
                if (c_b == hrht_pkg::CH_LF) begin
                    n_fs = hrht_pkg::f_fin(n_fs, hrht_pkg::ST_COMPLETE);
                    c_role = hrht_pkg::ROLE_DROP;
                end else begin
                    n_fs = hrht_pkg::f_fin(n_fs, (int'(n_lc) >= hrht_pkg::MAX_HEADERS) ?
                                           hrht_pkg::ST_MANY : hrht_pkg::ST_END);
                    c_role = hrht_pkg::ROLE_AFTER;
                end
                n_ph = hrht_pkg::PH_DONE;
                c_res[c_n] = hrht_pkg::f_res(hrht_pkg::CH_CR, hrht_pkg::ROLE_DROP, n_lc,
                                             c_q0, n_fs);
                c_n = c_n + 2'd1;
                c_res[c_n] = hrht_pkg::f_res(c_b, c_role, n_lc, c_pos, n_fs);
                c_n = c_n + 2'd1;
            end
            hrht_pkg::PH_VAL_LF: begin
                n_pc = 2'd0;
                if (hrht_pkg::f_blank(c_b)) begin
                    n_vs = 1'b1;
                    n_ph = hrht_pkg::PH_VALUE;
                    c_res[c_n] = hrht_pkg::f_res(hrht_pkg::CH_SP, hrht_pkg::ROLE_VALUE,
                                                 n_lc, c_q0, n_fs);
                    c_n = c_n + 2'd1;
                    if (c_last) begin
                        n_fs = hrht_pkg::f_fin(n_fs, hrht_pkg::ST_END);
                        n_ph = hrht_pkg::PH_DONE;
                    end
                    c_res[c_n] = hrht_pkg::f_res(hrht_pkg::CH_SP, hrht_pkg::ROLE_VALUE,
                                                 n_lc, c_pos, n_fs);
                    c_n = c_n + 2'd1;
                end else begin
                    c_res[c_n] = hrht_pkg::f_res(hrht_pkg::CH_LF, hrht_pkg::ROLE_DROP,
                                                 n_lc, c_q0, n_fs);
                    c_n = c_n + 2'd1;
                    if (int'(n_lc) < hrht_pkg::MAX_HEADERS) begin
                        n_lc = n_lc + 1'b1;
                    end
                    n_ph = hrht_pkg::PH_LINE;
                    c_mode = MD_LINE;
                end
            end
            hrht_pkg::PH_VAL_CR: begin
                n_pc = 2'd0;
                if (c_b != hrht_pkg::CH_LF) begin
                    n_vs = 1'b1;
                    n_ph = hrht_pkg::PH_VALUE;
                    c_res[c_n] = hrht_pkg::f_res(hrht_pkg::CH_CR, hrht_pkg::ROLE_VALUE,
                                                 n_lc, c_q0, n_fs);
                    c_n = c_n + 2'd1;
                    c_mode = MD_VALUE;
                end else if (c_last) begin
                    n_fs = hrht_pkg::f_fin(n_fs, hrht_pkg::ST_END);
                    n_ph = hrht_pkg::PH_DONE;
                    c_res[c_n] = hrht_pkg::f_res(hrht_pkg::CH_CR, hrht_pkg::ROLE_DROP,
                                                 n_lc, c_q0, n_fs);
                    c_n = c_n + 2'd1;
                    c_res[c_n] = hrht_pkg::f_res(c_b, hrht_pkg::ROLE_DROP, n_lc, c_pos,
                                                 n_fs);
                    c_n = c_n + 2'd1;
                end else begin
                    n_p0 = hrht_pkg::CH_CR;
                    n_p1 = hrht_pkg::CH_LF;
                    n_pc = 2'd2;
                    n_ph = hrht_pkg::PH_VAL_CRLF;
                end
            end
            hrht_pkg::PH_VAL_CRLF: begin
                n_pc = 2'd0;
                if (hrht_pkg::f_blank(c_b)) begin
                    n_vs = 1'b1;
                    n_ph = hrht_pkg::PH_VALUE;
                    c_res[c_n] = hrht_pkg::f_res(hrht_pkg::CH_SP, hrht_pkg::ROLE_VALUE,
                                                 n_lc, c_q0, n_fs);
                    c_n = c_n + 2'd1;
                    c_res[c_n] = hrht_pkg::f_res(hrht_pkg::CH_SP, hrht_pkg::ROLE_VALUE,
                                                 n_lc, c_q1, n_fs);
                    c_n = c_n + 2'd1;
                    if (c_last) begin
                        n_fs = hrht_pkg::f_fin(n_fs, hrht_pkg::ST_END);
                        n_ph = hrht_pkg::PH_DONE;
                    end
                    c_res[c_n] = hrht_pkg::f_res(hrht_pkg::CH_SP, hrht_pkg::ROLE_VALUE,
                                                 n_lc, c_pos, n_fs);
                    c_n = c_n + 2'd1;
                end else begin
                    c_res[c_n] = hrht_pkg::f_res(hrht_pkg::CH_CR, hrht_pkg::ROLE_DROP,
                                                 n_lc, c_q0, n_fs);
                    c_n = c_n + 2'd1;
                    c_res[c_n] = hrht_pkg::f_res(hrht_pkg::CH_LF, hrht_pkg::ROLE_DROP,
                                                 n_lc, c_q1, n_fs);
                    c_n = c_n + 2'd1;
                    if (int'(n_lc) < hrht_pkg::MAX_HEADERS) begin
                        n_lc = n_lc + 1'b1;
                    end
                    n_ph = hrht_pkg::PH_LINE;
                    c_mode = MD_LINE;
                end
            end
            default: begin
                n_ph = hrht_pkg::PH_DONE;
                c_res[c_n] = hrht_pkg::f_res(c_b, hrht_pkg::ROLE_AFTER, n_lc, c_pos, n_fs);
                c_n = c_n + 2'd1;
            end
        endcase

        // request line
        if (c_mode == MD_REQ) begin
            c_role = hrht_pkg::ROLE_DROP;
            if (c_last) begin
                n_fs = hrht_pkg::f_fin(n_fs, hrht_pkg::ST_END);
                n_ph = hrht_pkg::PH_DONE;
            end else if (c_b == hrht_pkg::CH_SP && n_ph != hrht_pkg::PH_VERSION) begin
                n_ph = (n_ph == hrht_pkg::PH_METHOD) ? hrht_pkg::PH_URI :
                                                       hrht_pkg::PH_VERSION;
            end else if (c_b == hrht_pkg::CH_CR) begin
                c_role = hrht_pkg::ROLE_DROP;
            end else if (c_b == hrht_pkg::CH_LF) begin
                if (n_ph != hrht_pkg::PH_VERSION) begin
                    n_fs = hrht_pkg::f_fin(n_fs, hrht_pkg::ST_END);
                    n_ph = hrht_pkg::PH_DONE;
                end else begin
                    n_ph = hrht_pkg::PH_LINE;
                end
            end else begin
                c_role = (n_ph == hrht_pkg::PH_METHOD) ? hrht_pkg::ROLE_METHOD :
                         (n_ph == hrht_pkg::PH_URI)    ? hrht_pkg::ROLE_URI :
                                                         hrht_pkg::ROLE_VERSION;
            end
            c_res[c_n] = hrht_pkg::f_res(c_b, c_role, n_lc, c_pos, n_fs);
            c_n = c_n + 2'd1;
        end

        // start of a header line
        if (c_mode == MD_LINE) begin
            if (c_b == hrht_pkg::CH_LF) begin
                n_fs = hrht_pkg::f_fin(n_fs, hrht_pkg::ST_COMPLETE);
                n_ph = hrht_pkg::PH_DONE;
                c_res[c_n] = hrht_pkg::f_res(c_b, hrht_pkg::ROLE_DROP, n_lc, c_pos, n_fs);
                c_n = c_n + 2'd1;
            end else if (c_b == hrht_pkg::CH_CR) begin
                if (c_last) begin
                    n_fs = hrht_pkg::f_fin(n_fs, hrht_pkg::ST_END);
                    n_ph = hrht_pkg::PH_DONE;
                    c_res[c_n] = hrht_pkg::f_res(c_b, hrht_pkg::ROLE_DROP, n_lc, c_pos,
                                                 n_fs);
                    c_n = c_n + 2'd1;
                end else begin
                    n_p0 = c_b;
                    n_pc = 2'd1;
                    n_ph = hrht_pkg::PH_LINE_CR;
                end
            end else if (int'(n_lc) >= hrht_pkg::MAX_HEADERS) begin
                n_fs = hrht_pkg::f_fin(n_fs, hrht_pkg::ST_MANY);
                n_ph = hrht_pkg::PH_DONE;
                c_res[c_n] = hrht_pkg::f_res(c_b, hrht_pkg::ROLE_DROP, n_lc, c_pos, n_fs);
                c_n = c_n + 2'd1;
            end else begin
                n_ph   = hrht_pkg::PH_NAME;
                n_nbs  = 1'b0;
                c_mode = MD_NAME;
            end
        end

        // header name
        if (c_mode == MD_NAME) begin
            c_role = hrht_pkg::ROLE_DROP;
            if (c_b == hrht_pkg::CH_COLON) begin
                n_ph = hrht_pkg::PH_VALUE;
                n_vs = 1'b0;
            end else if (hrht_pkg::f_blank(c_b)) begin
                n_nbs = 1'b1;
            end else if (c_b == hrht_pkg::CH_CR || c_b == hrht_pkg::CH_LF) begin
                n_fs = hrht_pkg::f_fin(n_fs, hrht_pkg::ST_END);
                n_ph = hrht_pkg::PH_DONE;
            end else if (!n_nbs) begin
                c_role = hrht_pkg::ROLE_NAME;
            end
            if (c_last) begin
                n_fs = hrht_pkg::f_fin(n_fs, hrht_pkg::ST_END);
                n_ph = hrht_pkg::PH_DONE;
            end
            c_res[c_n] = hrht_pkg::f_res(c_b, c_role, n_lc, c_pos, n_fs);
            c_n = c_n + 2'd1;
        end

        // header value
        if (c_mode == MD_VALUE) begin
            if (c_b == hrht_pkg::CH_LF || c_b == hrht_pkg::CH_CR) begin
                if (c_last) begin
                    n_fs = hrht_pkg::f_fin(n_fs, hrht_pkg::ST_END);
                    n_ph = hrht_pkg::PH_DONE;
                    c_res[c_n] = hrht_pkg::f_res(c_b, hrht_pkg::ROLE_DROP, n_lc, c_pos,
                                                 n_fs);
                    c_n = c_n + 2'd1;
                end else begin
                    n_p0 = c_b;
                    n_pc = 2'd1;
                    n_ph = (c_b == hrht_pkg::CH_LF) ? hrht_pkg::PH_VAL_LF :
                                                      hrht_pkg::PH_VAL_CR;
                end
            end else begin
                if (hrht_pkg::f_blank(c_b) && !n_vs) begin
                    c_role = hrht_pkg::ROLE_DROP;
                end else begin
                    c_role = hrht_pkg::ROLE_VALUE;
                    n_vs   = 1'b1;
                end
                if (c_last) begin
                    n_fs = hrht_pkg::f_fin(n_fs, hrht_pkg::ST_END);
                    n_ph = hrht_pkg::PH_DONE;
                end
                c_res[c_n] = hrht_pkg::f_res(c_b, c_role, n_lc, c_pos, n_fs);
                c_n = c_n + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph   <= hrht_pkg::PH_METHOD;
            r_lc   <= '0;
            r_vs   <= 1'b0;
            r_nbs  <= 1'b0;
            r_fs   <= hrht_pkg::ST_RUN;
            r_pc   <= '0;
            r_p0   <= '0;
            r_p1   <= '0;
            r_posc <= '0;
            r_cnt  <= '0;
            r_idx  <= '0;
            r_run  <= 1'b0;
        end else begin
            r_run <= 1'b1;
            if (out_acc) begin
                if (out_last) begin
                    r_cnt <= '0;
                    r_idx <= '0;
                end else begin
                    r_idx <= r_idx + 2'd1;
                end
            end
            if (in_acc) begin
                r_ph   <= n_ph;
                r_lc   <= n_lc;
                r_vs   <= n_vs;
                r_nbs  <= n_nbs;
                r_fs   <= n_fs;
                r_pc   <= n_pc;
                r_p0   <= n_p0;
                r_p1   <= n_p1;
                r_posc <= n_posc;
                if (c_n != 2'd0) begin
                    r_cnt <= c_n;
                    r_idx <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && c_n != 2'd0) begin
            r_res <= c_res;
        end
    end

    `HRHT_ASSERT_IMPL(a_idx_in_range, i_clk, i_rst_n, r_cnt != 2'd0, r_idx < r_cnt)
    `HRHT_ASSERT_NEXT(a_idx_advance, i_clk, i_rst_n, out_acc && !out_last, r_idx == $past(r_idx) + 2'd1)
    `HRHT_ASSERT_NEXT(a_drain_empty, i_clk, i_rst_n, out_acc && out_last && !in_acc, r_cnt == 2'd0)
    `HRHT_ASSERT_IMPL(a_pend_phase, i_clk, i_rst_n, r_pc != 2'd0, r_ph == hrht_pkg::PH_LINE_CR || r_ph == hrht_pkg::PH_VAL_LF || r_ph == hrht_pkg::PH_VAL_CR || r_ph == hrht_pkg::PH_VAL_CRLF)
    `HRHT_ASSERT_IMPL(a_status_done, i_clk, i_rst_n, r_fs != hrht_pkg::ST_RUN, r_ph == hrht_pkg::PH_DONE)

endmodule
